// File: design/multi_level_page_table_walker_core_macros.svh
// Assertion helpers shared by the walker RTL.
`ifndef MULTI_LEVEL_PAGE_TABLE_WALKER_CORE_MACROS_SVH
`define MULTI_LEVEL_PAGE_TABLE_WALKER_CORE_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define MLPTW_ASSERT_ALWAYS(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) \
      else $error(msg);

// Same-cycle implication outside reset.
`define MLPTW_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

// File: design/mlptw_pkg.sv
package mlptw_pkg;

   // Fixed field widths of the transaction payloads
   localparam int VA_W = 30;
   localparam int PA_W = 18;

   typedef enum logic {
      OP_TRANSLATE = 1'b0,
      OP_ALLOCATE  = 1'b1
   } op_type;

   typedef struct packed {
      op_type            op;
      logic [VA_W-1:0]   va;
   } req_type;

   typedef struct packed {
      logic [PA_W-1:0]   phys_addr;
      logic              fault;
      logic              out_of_pages;
   } rsp_type;

endpackage

// File: design/multi_level_page_table_walker_core.sv
// Sequence, accept to rsp_valid with the output register free: a translate reads and checks
//   one entry per level walked (read, check), then responds; with no root it responds at once.
// Allocate: the walk to the first invalid entry, then for each new page: take, clear one
//   entry a cycle, link; a new root is not linked; a refusal takes no page.
// One transaction at a time: the next is accepted from the cycle in which rsp_valid rises.
// Synchronous active-high reset: no root, whole pool free; the table store is not cleared.
`include "multi_level_page_table_walker_core_macros.svh"

module multi_level_page_table_walker_core #(
   parameter int PAGE_OFFSET_BITS = 12,
   parameter int LEVEL_COUNT      = 2,
   parameter int PAGE_POOL        = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  mlptw_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output mlptw_pkg::rsp_type rsp_data
);
   import mlptw_pkg::*;

   localparam int IDX_BITS = PAGE_OFFSET_BITS - 3;
   localparam int PW       = (PAGE_POOL > 1) ? $clog2(PAGE_POOL) : 1;
   localparam int EW       = PW + 1;
   localparam int AW       = PW + IDX_BITS;
   localparam int DEPTH    = PAGE_POOL * (1 << IDX_BITS);
   localparam int NFW      = $clog2(PAGE_POOL + 1);
   localparam int CW       = NFW + 3;
   localparam int LVL_W    = (LEVEL_COUNT > 1) ? $clog2(LEVEL_COUNT) : 1;
   localparam int SPAN     = PAGE_OFFSET_BITS + LEVEL_COUNT * IDX_BITS;
   localparam int EXT_W    = (SPAN > VA_W) ? SPAN : VA_W;

   typedef enum logic [2:0] {
      S_IDLE,
      S_READ,
      S_CHECK,
      S_ALLOC,
      S_CLEAR,
      S_LINK,
      S_RESP
   } state_type;

   state_type           state_ff, state_in;
   op_type              op_ff, op_in;
   logic [VA_W-1:0]     va_ff, va_in;
   logic [LVL_W-1:0]    lvl_ff, lvl_in;
   logic [PW-1:0]       page_ff, page_in;
   logic [PW-1:0]       new_page_ff, new_page_in;
   logic [PW-1:0]       root_page_ff, root_page_in;
   logic                root_present_ff, root_present_in;
   logic                root_mode_ff, root_mode_in;
   logic [NFW-1:0]      next_free_ff, next_free_in;
   logic [IDX_BITS-1:0] clr_cnt_ff, clr_cnt_in;
   rsp_type             res_ff, res_in;
   rsp_type             rsp_data_ff, rsp_data_in;
   logic                rsp_valid_ff, rsp_valid_in;

   // Table store port signals
   logic                ram_wr_en;
   logic [AW-1:0]       ram_wr_addr;
   logic [EW-1:0]       ram_wr_data;
   logic                ram_rd_en;
   logic [AW-1:0]       ram_rd_addr;
   logic [EW-1:0]       ram_rd_data;

   logic [EXT_W-1:0]    va_ext;
   logic [IDX_BITS-1:0] idx_arr [LEVEL_COUNT];
   logic [IDX_BITS-1:0] cur_idx;
   logic [PW-1:0]       rd_page;
   logic                lvl_last;
   logic [CW-1:0]       pages_left;
   logic [CW-1:0]       need_root;
   logic [CW-1:0]       need_walk;

   mlptw_ram #(
      .WIDTH (EW),
      .DEPTH (DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Per-level index fields, most significant level first
   assign va_ext = EXT_W'(va_ff);
   always_comb begin
      for (int g = 0; g < LEVEL_COUNT; g++) begin
         idx_arr[g] = va_ext[PAGE_OFFSET_BITS + (LEVEL_COUNT - 1 - g) * IDX_BITS +: IDX_BITS];
      end
   end
   assign cur_idx  = idx_arr[lvl_ff];
   assign lvl_last = (lvl_ff == LVL_W'(LEVEL_COUNT - 1));
   assign rd_page  = ram_rd_data[EW-1:1];

   // Pool accounting for the up-front page check
   assign pages_left = CW'(PAGE_POOL) - CW'(next_free_ff);
   assign need_root  = CW'(LEVEL_COUNT + 1);
   assign need_walk  = CW'(LEVEL_COUNT) - CW'(lvl_ff);

   // Sequencer next-state logic
   always_comb begin
      state_in        = state_ff;
      op_in           = op_ff;
      va_in           = va_ff;
      lvl_in          = lvl_ff;
      page_in         = page_ff;
      new_page_in     = new_page_ff;
      root_page_in    = root_page_ff;
      root_present_in = root_present_ff;
      root_mode_in    = root_mode_ff;
      next_free_in    = next_free_ff;
      clr_cnt_in      = clr_cnt_ff;
      res_in          = res_ff;
      rsp_data_in     = rsp_data_ff;
      rsp_valid_in    = rsp_valid_ff;
      ram_wr_en       = 1'b0;
      ram_wr_addr     = {page_ff, cur_idx};
      ram_wr_data     = '0;
      ram_rd_en       = 1'b0;
      ram_rd_addr     = {page_ff, cur_idx};

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in        = req_data.op;
               va_in        = req_data.va;
               lvl_in       = '0;
               page_in      = root_page_ff;
               root_mode_in = 1'b0;
               res_in       = '0;
               if (root_present_ff) begin
                  state_in = S_READ;
               end else if (req_data.op == OP_TRANSLATE) begin
                  res_in.fault = 1'b1;
                  state_in     = S_RESP;
               end else if (need_root > pages_left) begin
                  res_in.out_of_pages = 1'b1;
                  state_in            = S_RESP;
               end else begin
                  root_mode_in = 1'b1;
                  state_in     = S_ALLOC;
               end
            end
         end
         S_READ: begin
            ram_rd_en = 1'b1;
            state_in  = S_CHECK;
         end
         S_CHECK: begin
            if (ram_rd_data[0]) begin
               page_in = rd_page;
               if (lvl_last) begin
                  if (op_ff == OP_TRANSLATE) begin
                     res_in.phys_addr = PA_W'({rd_page, va_ff[PAGE_OFFSET_BITS-1:0]});
                  end
                  state_in = S_RESP;
               end else begin
                  lvl_in   = lvl_ff + 1'b1;
                  state_in = S_READ;
               end
            end else if (op_ff == OP_TRANSLATE) begin
               res_in.fault = 1'b1;
               state_in     = S_RESP;
            end else if (need_walk > pages_left) begin
               res_in.out_of_pages = 1'b1;
               state_in            = S_RESP;
            end else begin
               state_in = S_ALLOC;
            end
         end
         S_ALLOC: begin
            // bump allocator hands out the next page
            new_page_in  = PW'(next_free_ff);
            next_free_in = next_free_ff + 1'b1;
            clr_cnt_in   = '0;
            state_in     = S_CLEAR;
         end
         S_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = {new_page_ff, clr_cnt_ff};
            ram_wr_data = '0;
            clr_cnt_in  = clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == '1) begin
               if (root_mode_ff) begin
                  root_page_in    = new_page_ff;
                  root_present_in = 1'b1;
                  page_in         = new_page_ff;
                  root_mode_in    = 1'b0;
                  state_in        = S_ALLOC;
               end else begin
                  state_in = S_LINK;
               end
            end
         end
         S_LINK: begin
            // point the parent entry at the freshly cleared page
            ram_wr_en   = 1'b1;
            ram_wr_addr = {page_ff, cur_idx};
            ram_wr_data = {new_page_ff, 1'b1};
            page_in     = new_page_ff;
            if (lvl_last) begin
               state_in = S_RESP;
            end else begin
               lvl_in   = lvl_ff + 1'b1;
               state_in = S_ALLOC;
            end
         end
         S_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_data_in  = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         root_page_ff    <= '0;
         root_present_ff <= 1'b0;
         root_mode_ff    <= 1'b0;
         next_free_ff    <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         op_ff           <= op_in;
         va_ff           <= va_in;
         lvl_ff          <= lvl_in;
         page_ff         <= page_in;
         new_page_ff     <= new_page_in;
         root_page_ff    <= root_page_in;
         root_present_ff <= root_present_in;
         root_mode_ff    <= root_mode_in;
         next_free_ff    <= next_free_in;
         clr_cnt_ff      <= clr_cnt_in;
         res_ff          <= res_in;
         rsp_data_ff     <= rsp_data_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `MLPTW_ASSERT_ALWAYS(a_pool_bound, next_free_ff <= NFW'(PAGE_POOL), "allocator ran past the pool")
   `MLPTW_ASSERT_IMPLY(a_root_allocated, root_present_ff,
      NFW'(root_page_ff) < next_free_ff, "root page never handed out")
   `MLPTW_ASSERT_IMPLY(a_fault_clean, rsp_valid_ff && rsp_data_ff.fault,
      rsp_data_ff.phys_addr == '0 && !rsp_data_ff.out_of_pages, "fault result carries payload")
   `MLPTW_ASSERT_IMPLY(a_alloc_only, !$past(reset) && next_free_ff != $past(next_free_ff),
      $past(state_ff) == S_ALLOC, "page taken outside allocation step")

endmodule

// File: design/mlptw_ram.sv
module mlptw_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
   import mlptw_pkg::*;

   // Block configuration (matches the instance below)
   localparam int OFS_BITS  = 12;
   localparam int LEVELS    = 2;
   localparam int POOL      = 64;
   localparam int IDX_W     = OFS_BITS - 3;
   localparam int ENTRIES   = 1 << IDX_W;
   localparam int PAGE_W    = $clog2(POOL);
   localparam int ENTRY_W   = PAGE_W + 1;
   localparam int VPN_W     = VA_W - OFS_BITS;
   localparam int OFS_MASK  = (1 << OFS_BITS) - 1;

   // Run control
   localparam int QUIET_LIMIT  = 8000;
   localparam int HOLD_CYCLES  = 400;
   localparam int DRAIN_CYCLES = 20;
   localparam int RANDOM_ITEMS = 500;

   logic    clock;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   multi_level_page_table_walker_core #(
      .PAGE_OFFSET_BITS(OFS_BITS),
      .LEVEL_COUNT     (LEVELS),
      .PAGE_POOL       (POOL)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // Page table shadow: store, root and bump allocator
   // ------------------------------------------------------------------
   logic [ENTRY_W-1:0] pt_mem [POOL*ENTRIES];
   logic [PAGE_W-1:0]  pt_root;
   bit                 pt_root_valid = 1'b0;
   int                 pt_next_free  = 0;

   // virtual page numbers with a complete mapping path
   logic [VPN_W-1:0]   mapped_pages[$];
   rsp_type            expected_walks[$];

   int  mismatch_count = 0;
   int  rsp_count      = 0;
   int  quiet_cycles   = 0;
   int  req_idle_pct   = 0;
   int  rsp_idle_pct   = 0;
   bit  rsp_hold       = 1'b0;

   function automatic logic [IDX_W-1:0] level_idx(logic [VA_W-1:0] va, int lvl);
      return IDX_W'(va >> (OFS_BITS + (LEVELS - 1 - lvl) * IDX_W));
   endfunction

   function automatic int pages_left();
      return POOL - pt_next_free;
   endfunction

   // pages an allocate of va would take: root if absent, then one per missing level
   function automatic int pages_needed(logic [VA_W-1:0] va);
      int page;
      logic [ENTRY_W-1:0] e;
      if (!pt_root_valid) return 1 + LEVELS;
      page = pt_root;
      for (int lvl = 0; lvl < LEVELS; lvl++) begin
         e = pt_mem[page*ENTRIES + level_idx(va, lvl)];
         if (!e[0]) return LEVELS - lvl;
         page = e[ENTRY_W-1:1];
      end
      return 0;
   endfunction

   // hand out the next page and clear it
   function automatic int grab_page();
      int p;
      p = pt_next_free;
      pt_next_free++;
      for (int i = 0; i < ENTRIES; i++) pt_mem[p*ENTRIES + i] = '0;
      return p;
   endfunction

   // expected response for one transaction; updates the shadow table
   function automatic rsp_type predict_walk(op_type op, logic [VA_W-1:0] va);
      rsp_type r;
      int page;
      int need;
      int slot;
      logic [ENTRY_W-1:0] e;
      logic [31:0] phys;
      r = '0;
      if (op == OP_TRANSLATE) begin
         if (!pt_root_valid) begin
            r.fault = 1'b1;
            return r;
         end
         page = pt_root;
         for (int lvl = 0; lvl < LEVELS; lvl++) begin
            e = pt_mem[page*ENTRIES + level_idx(va, lvl)];
            if (!e[0]) begin
               r.fault = 1'b1;
               return r;
            end
            page = e[ENTRY_W-1:1];
         end
         phys = (32'(page) << OFS_BITS) | (32'(va) & OFS_MASK);
         r.phys_addr = phys[PA_W-1:0];
         return r;
      end
      // allocate: all-or-nothing on pool space
      need = pages_needed(va);
      if (need == 0) return r;
      if (need > pages_left()) begin
         r.out_of_pages = 1'b1;
         return r;
      end
      if (!pt_root_valid) begin
         pt_root       = PAGE_W'(grab_page());
         pt_root_valid = 1'b1;
      end
      page = pt_root;
      for (int lvl = 0; lvl < LEVELS; lvl++) begin
         slot = page*ENTRIES + level_idx(va, lvl);
         e    = pt_mem[slot];
         if (!e[0]) begin
            e = {PAGE_W'(grab_page()), 1'b1};
            pt_mem[slot] = e;
         end
         page = e[ENTRY_W-1:1];
      end
      mapped_pages.push_back(va[VA_W-1:OFS_BITS]);
      return r;
   endfunction

   // random address whose allocate needs exactly 'need' pages (1 or 2)
   function automatic logic [VA_W-1:0] fresh_va(int need);
      logic [VA_W-1:0] va;
      logic [VPN_W-1:0] vpn;
      do begin
         va = VA_W'($urandom);
         if (need == 1) begin
            vpn = mapped_pages[$urandom_range(mapped_pages.size() - 1)];
            va[VA_W-1 -: IDX_W] = vpn[VPN_W-1 -: IDX_W];
         end
      end while (pages_needed(va) != need);
      return va;
   endfunction

   function automatic logic [VA_W-1:0] mapped_va();
      logic [VA_W-1:0] va;
      va = VA_W'($urandom);
      va[VA_W-1:OFS_BITS] = mapped_pages[$urandom_range(mapped_pages.size() - 1)];
      return va;
   endfunction

   // ------------------------------------------------------------------
   // Request side: one transaction per call, entered and left at negedge
   // ------------------------------------------------------------------
   task automatic send_item(input op_type op, input logic [VA_W-1:0] va);
      req_type item;
      item.op = op;
      item.va = va;
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
      expected_walks.push_back(predict_walk(op, va));
      @(negedge clock);
   endtask

   task automatic set_idling(input int req_pct, input int rsp_pct);
      req_idle_pct = req_pct;
      rsp_idle_pct = rsp_pct;
   endtask

   // Response side: random stall, plus a forced hold-off
   always @(negedge clock) begin
      rsp_stall <= rsp_hold || ($urandom_range(99) < rsp_idle_pct);
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("ERROR result %0d %s: got 0x%0h, expected 0x%0h", rsp_count, what, got, want);
      mismatch_count++;
   endtask

   // Compare every accepted response against the oldest expectation
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_walks.size() == 0) begin
            report_mismatch("unexpected transaction", 32'(rsp_data), 32'h0);
         end else begin
            want = expected_walks.pop_front();
            if (rsp_data.phys_addr !== want.phys_addr)
               report_mismatch("phys_addr", 32'(rsp_data.phys_addr), 32'(want.phys_addr));
            if (rsp_data.fault !== want.fault)
               report_mismatch("fault", 32'(rsp_data.fault), 32'(want.fault));
            if (rsp_data.out_of_pages !== want.out_of_pages)
               report_mismatch("out_of_pages", 32'(rsp_data.out_of_pages),
                               32'(want.out_of_pages));
         end
         rsp_count++;
      end
   end

   // Watchdog: cycles without any handshake on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      while (quiet_cycles < QUIET_LIMIT) @(posedge clock);
      $display("tb_top NOT OK");
      $finish;
   end

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // translate before any allocate: no root
   task automatic test_no_root();
      send_item(OP_TRANSLATE, '0);
      send_item(OP_TRANSLATE, '1);
   endtask

   // build the first path, then hit it with both offset extremes
   task automatic test_first_mapping();
      send_item(OP_ALLOCATE, '0);
      send_item(OP_TRANSLATE, '0);
      send_item(OP_TRANSLATE, VA_W'(OFS_MASK));
   endtask

   // invalid entry at the last level, then at the top level, then at the last level again
   task automatic test_walk_faults();
      send_item(OP_TRANSLATE, VA_W'(1) << OFS_BITS);
      send_item(OP_TRANSLATE, VA_W'(1) << (OFS_BITS + IDX_W));
      send_item(OP_TRANSLATE, VA_W'(OFS_MASK) << IDX_W);
   endtask

   // complete paths leave the table alone; partial paths add only what is missing
   task automatic test_existing_path();
      send_item(OP_ALLOCATE, VA_W'(OFS_MASK));
      send_item(OP_ALLOCATE, '1);
      send_item(OP_ALLOCATE, {{IDX_W{1'b1}}, {(VA_W-IDX_W){1'b0}}});
      send_item(OP_TRANSLATE, '1);
      send_item(OP_TRANSLATE, {{IDX_W{1'b1}}, {(VA_W-IDX_W-OFS_BITS){1'b0}}, 12'hABC});
      send_item(OP_ALLOCATE, {{(VA_W-OFS_BITS){1'b1}}, {OFS_BITS{1'b0}}});
      send_item(OP_TRANSLATE, {{IDX_W{1'b0}}, {IDX_W{1'b1}}, 12'h5A5});
   endtask

   // mixed traffic; fresh allocations stop short of the last pages
   task automatic test_random_traffic(input int count);
      int pick;
      repeat (count) begin
         pick = $urandom_range(99);
         if (pick < 55) begin
            send_item(OP_TRANSLATE, mapped_va());
         end else if (pick < 65) begin
            send_item(OP_TRANSLATE, fresh_va(1) | (mapped_va() & VA_W'(OFS_MASK)));
         end else if (pick < 78) begin
            send_item(OP_TRANSLATE, VA_W'($urandom));
         end else if (pick < 88) begin
            send_item(OP_ALLOCATE, mapped_va());
         end else if (pages_left() >= 3 || pages_left() == 0) begin
            send_item(OP_ALLOCATE, fresh_va($urandom_range(1, 2)));
         end else begin
            send_item(OP_TRANSLATE, VA_W'($urandom));
         end
      end
   endtask

   // receiver holds off while the sender keeps offering transactions
   task automatic test_receiver_hold();
      @(posedge clock);
      rsp_hold = 1'b1;
      fork
         begin
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_hold = 1'b0;
         end
      join_none
      @(negedge clock);
      repeat (16) begin
         if ($urandom_range(1))
            send_item(OP_TRANSLATE, mapped_va());
         else
            send_item(OP_TRANSLATE, VA_W'($urandom));
      end
   endtask

   // use up the pool; a two-page request against one free page must fail cleanly
   task automatic test_pool_exhaust();
      logic [VA_W-1:0] va;
      while (pages_left() >= 2) send_item(OP_ALLOCATE, fresh_va(2));
      if (pages_left() == 1) begin
         send_item(OP_ALLOCATE, fresh_va(2));
         send_item(OP_ALLOCATE, fresh_va(1));
      end
      send_item(OP_ALLOCATE, fresh_va(1));
      va = fresh_va(2);
      send_item(OP_ALLOCATE, va);
      send_item(OP_TRANSLATE, va);
      send_item(OP_ALLOCATE, mapped_va());
   endtask

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      set_idling(21, 76);
      test_no_root();
      test_first_mapping();
      test_walk_faults();
      test_existing_path();
      test_random_traffic(RANDOM_ITEMS);
      test_receiver_hold();

      set_idling(76, 21);
      test_random_traffic(RANDOM_ITEMS);
      test_pool_exhaust();

      set_idling(0, 0);
      test_random_traffic(RANDOM_ITEMS);

      // drain outstanding transactions
      req_valid <= 1'b0;
      while (expected_walks.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0)
         $display("tb_top OK");
      else
         $display("tb_top NOT OK");
      $finish;
   end

endmodule
